>>> design/tle_pkg.sv
// shared constants and types for the terminal line editor
package tle_pkg;

	localparam int LINE_CAPACITY = 256;
	localparam int IDX_W = $clog2(LINE_CAPACITY);

	typedef logic [IDX_W-1:0] tle_idx_t;

	localparam tle_idx_t LEN_MAX = IDX_W'(LINE_CAPACITY - 1);

	localparam logic [7:0] KEY_BS = 8'd8;
	localparam logic [7:0] KEY_NL = 8'd10;
	localparam logic [7:0] KEY_CR = 8'd13;
	localparam logic [7:0] KEY_ESC = 8'h1b;
	localparam logic [7:0] KEY_DEL = 8'd127;
	localparam logic [7:0] KEY_SPACE = 8'd32;
	localparam logic [7:0] KEY_TILDE = 8'h7e;
	localparam logic [7:0] KEY_BRACKET = 8'h5b;
	localparam logic [7:0] KEY_ZERO = 8'h30;
	localparam logic [7:0] KEY_THREE = 8'h33;
	localparam logic [7:0] KEY_NINE = 8'h39;
	localparam logic [7:0] KEY_UP = 8'h41;
	localparam logic [7:0] KEY_DOWN = 8'h42;
	localparam logic [7:0] KEY_RIGHT = 8'h43;
	localparam logic [7:0] KEY_LEFT = 8'h44;
	localparam logic [7:0] KEY_END = 8'h46;
	localparam logic [7:0] KEY_HOME = 8'h48;

	localparam logic OP_KEY = 1'b0;
	localparam logic OP_READ = 1'b1;

	typedef enum logic [1:0] {
		ESC_IDLE = 2'd0,
		ESC_OPEN = 2'd1,
		ESC_FINAL = 2'd2,
		ESC_DIGIT = 2'd3
	} tle_esc_t;

	typedef enum logic [2:0] {
		EV_NONE = 3'd0,
		EV_REDRAW = 3'd1,
		EV_DONE = 3'd2,
		EV_HIST_UP = 3'd3,
		EV_HIST_DOWN = 3'd4,
		EV_READ = 3'd5
	} tle_event_t;

endpackage

>>> design/tle_ram.sv
// generic single-port-write ram with registered read
module tle_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> design/terminal_line_editor_top.sv
// top level of the terminal line editor: key decode, shift sequencer and line ram
//
// Takes one word at a time and returns exactly one result word per input word.
// A key byte that inserts or deletes a character moves the characters behind
// the edit point one position, one at a time, through the single line ram
// (read, then write). An insert then writes the new character. A read inside
// the line reads the line ram, and a read beyond it does not. The input is not
// ready while a word is being worked on. A finished result waits in the output
// register until taken, and the next result is held back until that one has
// gone. No clearing pass is needed after reset.
module terminal_line_editor_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,   // key_byte, read_index
	input  logic [0:0]  s_axis_tuser,   // op
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,   // length_now, cursor_now, char_read
	output logic [2:0]  m_axis_tuser    // event_res
);

	localparam int W = tle_pkg::IDX_W;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SH_RD,
		ST_SH_WR,
		ST_INS,
		ST_RD,
		ST_RD_CAP,
		ST_OUT
	} state_t;

	typedef enum logic [1:0] {
		ACT_NONE,
		ACT_INS,
		ACT_DEL
	} act_t;

	state_t               state_q;
	tle_pkg::tle_idx_t    len_q, cur_q, ptr_q, lim_q;
	tle_pkg::tle_esc_t    phase_q;
	logic                 bracket_q, three_q, fin_q, ins_q;
	logic [7:0]           char_q, ch_q;
	tle_pkg::tle_event_t  ev_q;
	logic                 m_valid_q;
	logic [23:0]          m_data_q;
	logic [2:0]           m_user_q;

	logic [7:0]           key, ridx;
	logic                 accept;
	tle_pkg::tle_idx_t    len0, cur0, step, del_pos, nlen, ncur;
	tle_pkg::tle_esc_t    nphase;
	logic                 nbr, nthree, nfin;
	tle_pkg::tle_event_t  ev;
	act_t                 act;
	logic [W+7:0]         idx_wide, len_wide, cur_wide;
	logic                 ram_we;
	tle_pkg::tle_idx_t    ram_waddr, ram_raddr;
	logic [7:0]           ram_wdata, ram_rdata;

	assign key = s_axis_tdata[7:0];
	assign ridx = s_axis_tdata[15:8];
	assign s_axis_tready = (state_q == ST_IDLE);
	assign accept = s_axis_tvalid && s_axis_tready;
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata = m_data_q;
	assign m_axis_tuser = m_user_q;

	assign len0 = fin_q ? '0 : len_q;
	assign cur0 = fin_q ? '0 : cur_q;
	assign idx_wide = {{W{1'b0}}, ridx};
	assign len_wide = {8'd0, len_q};
	assign cur_wide = {8'd0, cur_q};

	// shared step unit for the shift loop
	assign step = ins_q ? ptr_q - 1'b1 : ptr_q + 1'b1;

	always_comb begin
		ev = tle_pkg::EV_NONE;
		act = ACT_NONE;
		nlen = len0;
		ncur = cur0;
		del_pos = cur0;
		nphase = phase_q;
		nbr = bracket_q;
		nthree = three_q;
		nfin = 1'b0;
		case (phase_q)
			tle_pkg::ESC_OPEN: begin
				nbr = (key == tle_pkg::KEY_BRACKET);
				nphase = tle_pkg::ESC_FINAL;
			end
			tle_pkg::ESC_FINAL: begin
				nphase = tle_pkg::ESC_IDLE;
				if (bracket_q) begin
					if (key inside {[tle_pkg::KEY_ZERO:tle_pkg::KEY_NINE]}) begin
						nthree = (key == tle_pkg::KEY_THREE);
						nphase = tle_pkg::ESC_DIGIT;
					end else begin
						case (key)
							tle_pkg::KEY_UP: ev = tle_pkg::EV_HIST_UP;
							tle_pkg::KEY_DOWN: ev = tle_pkg::EV_HIST_DOWN;
							tle_pkg::KEY_RIGHT: begin
								if (cur0 != len0) begin
									ncur = cur0 + 1'b1;
									ev = tle_pkg::EV_REDRAW;
								end
							end
							tle_pkg::KEY_LEFT: begin
								if (cur0 != '0) begin
									ncur = cur0 - 1'b1;
									ev = tle_pkg::EV_REDRAW;
								end
							end
							tle_pkg::KEY_HOME: begin
								if (cur0 != '0) begin
									ncur = '0;
									ev = tle_pkg::EV_REDRAW;
								end
							end
							tle_pkg::KEY_END: begin
								if (cur0 != len0) begin
									ncur = len0;
									ev = tle_pkg::EV_REDRAW;
								end
							end
							default: ev = tle_pkg::EV_NONE;
						endcase
					end
				end
			end
			tle_pkg::ESC_DIGIT: begin
				nphase = tle_pkg::ESC_IDLE;
				if (key == tle_pkg::KEY_TILDE && three_q && cur0 != len0) begin
					act = ACT_DEL;
					del_pos = cur0;
					nlen = len0 - 1'b1;
					ev = tle_pkg::EV_REDRAW;
				end
			end
			default: begin
				if (key == tle_pkg::KEY_ESC) begin
					nphase = tle_pkg::ESC_OPEN;
					nbr = 1'b0;
					nthree = 1'b0;
				end else if (key == tle_pkg::KEY_NL) begin
					nfin = 1'b1;
					ev = tle_pkg::EV_DONE;
				end else if (key == tle_pkg::KEY_BS || key == tle_pkg::KEY_DEL) begin
					if (cur0 != '0) begin
						act = ACT_DEL;
						ncur = cur0 - 1'b1;
						del_pos = cur0 - 1'b1;
						nlen = len0 - 1'b1;
						ev = tle_pkg::EV_REDRAW;
					end
				end else if (key inside {[tle_pkg::KEY_SPACE:8'd126]}) begin
					if (len0 != tle_pkg::LEN_MAX) begin
						act = ACT_INS;
						nlen = len0 + 1'b1;
						ncur = cur0 + 1'b1;
						ev = tle_pkg::EV_REDRAW;
					end
				end
			end
		endcase
	end

	always_comb begin
		ram_we = 1'b0;
		ram_waddr = ptr_q;
		ram_wdata = ram_rdata;
		ram_raddr = step;
		case (state_q)
			ST_SH_WR: ram_we = 1'b1;
			ST_INS: begin
				ram_we = 1'b1;
				ram_waddr = lim_q;
				ram_wdata = char_q;
			end
			ST_RD: ram_raddr = ptr_q;
			default: ram_we = 1'b0;
		endcase
	end

	tle_ram #(
		.WIDTH(8),
		.DEPTH(tle_pkg::LINE_CAPACITY)
	) u_line_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			len_q <= '0;
			cur_q <= '0;
			phase_q <= tle_pkg::ESC_IDLE;
			bracket_q <= 1'b0;
			three_q <= 1'b0;
			fin_q <= 1'b0;
			ins_q <= 1'b0;
			m_valid_q <= 1'b0;
			ptr_q <= '0;
			lim_q <= '0;
			char_q <= '0;
			ch_q <= '0;
			ev_q <= tle_pkg::EV_NONE;
			m_data_q <= '0;
			m_user_q <= '0;
		end else begin
			if (m_axis_tready && state_q != ST_OUT) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						ch_q <= '0;
						if (s_axis_tuser[0] == tle_pkg::OP_READ) begin
							ev_q <= tle_pkg::EV_READ;
							ptr_q <= idx_wide[W-1:0];
							state_q <= (idx_wide < len_wide) ? ST_RD : ST_OUT;
						end else begin
							ev_q <= ev;
							len_q <= nlen;
							cur_q <= ncur;
							phase_q <= nphase;
							bracket_q <= nbr;
							three_q <= nthree;
							fin_q <= nfin;
							char_q <= key;
							case (act)
								ACT_INS: begin
									ins_q <= 1'b1;
									ptr_q <= len0;
									lim_q <= cur0;
									state_q <= (len0 == cur0) ? ST_INS : ST_SH_RD;
								end
								ACT_DEL: begin
									ins_q <= 1'b0;
									ptr_q <= del_pos;
									lim_q <= len0 - 1'b1;
									state_q <= (del_pos == len0 - 1'b1) ? ST_OUT : ST_SH_RD;
								end
								default: state_q <= ST_OUT;
							endcase
						end
					end
				end
				ST_SH_RD: state_q <= ST_SH_WR;
				ST_SH_WR: begin
					ptr_q <= step;
					if (step == lim_q) begin
						state_q <= ins_q ? ST_INS : ST_OUT;
					end else begin
						state_q <= ST_SH_RD;
					end
				end
				ST_INS: state_q <= ST_OUT;
				ST_RD: state_q <= ST_RD_CAP;
				ST_RD_CAP: begin
					ch_q <= ram_rdata;
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (!m_valid_q || m_axis_tready) begin
						m_valid_q <= 1'b1;
						m_data_q <= {ch_q, cur_wide[7:0], len_wide[7:0]};
						m_user_q <= ev_q;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef SYNTH
	a_cursor_in_line: assert property (@(posedge clk) disable iff (!arst_n)
		cur_q <= len_q)
		else $error("cursor beyond line length");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !s_axis_tready)
		else $error("input ready right after accepting a word");

	a_shift_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SH_RD) |-> (ptr_q != lim_q))
		else $error("shift loop ran past its limit");
`endif

endmodule

>>> sim/tb_top.sv
// testbench for the terminal line editor: key and read words against a line predictor
`timescale 1ns / 1ps

module tb_top;
	import tle_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int HOLD_CYCLES = 300;
	localparam int DRAIN_CYCLES = 600;

	typedef struct packed {
		logic       op;
		logic [7:0] key;
		logic [7:0] idx;
	} line_word_t;

	typedef struct packed {
		tle_event_t ev;
		logic [7:0] len;
		logic [7:0] cur;
		logic [7:0] ch;
	} line_result_t;

	localparam logic [7:0] SEQ_FINALS [6] = '{KEY_UP, KEY_DOWN, KEY_RIGHT, KEY_LEFT,
		KEY_HOME, KEY_END};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata = 16'd0;   // key_byte, read_index
	logic [0:0]  s_axis_tuser = 1'b0;    // op
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [23:0] m_axis_tdata;           // length_now, cursor_now, char_read
	logic [2:0]  m_axis_tuser;           // event_res

	terminal_line_editor_top u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predicted line state
	logic [7:0] line_mem [LINE_CAPACITY];
	int         line_len = 0;
	int         line_cur = 0;
	tle_esc_t   esc_state = ESC_IDLE;
	bit         esc_bracket = 1'b0;
	bit         esc_three = 1'b0;
	bit         line_done = 1'b0;

	line_word_t   key_words[$];
	line_result_t awaited_results[$];
	line_word_t   word_on_bus;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_req = 0;
	int hold_ack = 0;
	int hold_left = 0;
	int fails = 0;
	int words_sent = 0;
	int words_checked = 0;
	int events_seen [6];
	int idle_cycles = 0;

	function automatic tle_event_t remove_char(input int pos);
		if (pos >= line_len)
			return EV_NONE;
		for (int i = pos; i + 1 < line_len; i++)
			line_mem[i] = line_mem[i + 1];
		line_len--;
		return EV_REDRAW;
	endfunction

	function automatic line_result_t edit_line(input line_word_t w);
		line_result_t r;
		r.ev = EV_NONE;
		r.ch = 8'd0;
		if (w.op == OP_READ) begin
			r.ev = EV_READ;
			if (int'(w.idx) < line_len)
				r.ch = line_mem[w.idx];
		end else begin
			if (line_done) begin
				line_len = 0;
				line_cur = 0;
				line_done = 1'b0;
			end
			case (esc_state)
				ESC_OPEN: begin
					esc_bracket = (w.key == KEY_BRACKET);
					esc_state = ESC_FINAL;
				end
				ESC_FINAL: begin
					esc_state = ESC_IDLE;
					if (esc_bracket) begin
						if (w.key >= KEY_ZERO && w.key <= KEY_NINE) begin
							esc_three = (w.key == KEY_THREE);
							esc_state = ESC_DIGIT;
						end else begin
							case (w.key)
								KEY_UP: r.ev = EV_HIST_UP;
								KEY_DOWN: r.ev = EV_HIST_DOWN;
								KEY_RIGHT: if (line_cur < line_len) begin
									line_cur++;
									r.ev = EV_REDRAW;
								end
								KEY_LEFT: if (line_cur > 0) begin
									line_cur--;
									r.ev = EV_REDRAW;
								end
								KEY_HOME: if (line_cur != 0) begin
									line_cur = 0;
									r.ev = EV_REDRAW;
								end
								KEY_END: if (line_cur != line_len) begin
									line_cur = line_len;
									r.ev = EV_REDRAW;
								end
								default: r.ev = EV_NONE;
							endcase
						end
					end
				end
				ESC_DIGIT: begin
					esc_state = ESC_IDLE;
					if (w.key == KEY_TILDE && esc_three)
						r.ev = remove_char(line_cur);
				end
				default: begin
					if (w.key == KEY_ESC) begin
						esc_state = ESC_OPEN;
						esc_bracket = 1'b0;
						esc_three = 1'b0;
					end else if (w.key == KEY_NL) begin
						line_done = 1'b1;
						r.ev = EV_DONE;
					end else if (w.key == KEY_BS || w.key == KEY_DEL) begin
						if (line_cur != 0) begin
							line_cur--;
							r.ev = remove_char(line_cur);
						end
					end else if (w.key >= KEY_SPACE && w.key < KEY_DEL) begin
						if (line_len + 1 < LINE_CAPACITY) begin
							for (int i = line_len; i > line_cur; i--)
								line_mem[i] = line_mem[i - 1];
							line_mem[line_cur] = w.key;
							line_len++;
							line_cur++;
							r.ev = EV_REDRAW;
						end
					end
				end
			endcase
		end
		r.len = line_len[7:0];
		r.cur = line_cur[7:0];
		return r;
	endfunction

	task automatic queue_key(input logic [7:0] b);
		line_word_t w;
		w.op = OP_KEY;
		w.key = b;
		w.idx = 8'($urandom_range(255));
		key_words.push_back(w);
	endtask

	task automatic queue_read(input logic [7:0] idx);
		line_word_t w;
		w.op = OP_READ;
		w.key = 8'($urandom_range(255));
		w.idx = idx;
		key_words.push_back(w);
	endtask

	task automatic queue_random_action();
		int pick;
		pick = $urandom_range(99);
		if (pick < 40) begin
			queue_key(8'($urandom_range(126, 32)));
		end else if (pick < 48) begin
			queue_key($urandom_range(1) ? KEY_BS : KEY_DEL);
		end else if (pick < 63) begin
			queue_key(KEY_ESC);
			queue_key(KEY_BRACKET);
			queue_key(SEQ_FINALS[$urandom_range(5)]);
		end else if (pick < 68) begin
			queue_key(KEY_ESC);
			queue_key(KEY_BRACKET);
			queue_key(KEY_THREE);
			queue_key(KEY_TILDE);
		end else if (pick < 71) begin
			queue_key(KEY_ESC);
			queue_key(KEY_BRACKET);
			queue_key(8'(KEY_ZERO + $urandom_range(9)));
			queue_key($urandom_range(1) ? KEY_TILDE : 8'($urandom_range(255)));
		end else if (pick < 74) begin
			queue_key(KEY_ESC);
			queue_key(8'($urandom_range(255)));
			queue_key(8'($urandom_range(255)));
		end else if (pick < 78) begin
			queue_key(KEY_NL);
		end else if (pick < 80) begin
			queue_key(KEY_CR);
		end else if (pick < 90) begin
			case ($urandom_range(19))
				0, 1, 2: queue_read(8'($urandom_range(255)));
				3, 4, 5, 6, 7: queue_read(8'($urandom_range(63)));
				default: queue_read(8'($urandom_range(15)));
			endcase
		end else begin
			queue_key(8'($urandom_range(255)));
		end
	endtask

	task automatic wait_drained();
		@(negedge clk);
		while (key_words.size() != 0 || s_axis_tvalid || awaited_results.size() != 0)
			@(negedge clk);
	endtask

	task automatic run_random_phase(input int send_pct, input int recv_pct, input int count);
		int target;
		send_idle_pct = send_pct;
		recv_stall_pct = recv_pct;
		target = key_words.size() + count;
		while (key_words.size() < target)
			queue_random_action();
		wait_drained();
	endtask

	task automatic check_field(input string name, input logic [7:0] want,
		input logic [7:0] seen);
		if (want !== seen) begin
			$error("%s expected %0d got %0d", name, want, seen);
			fails++;
		end
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				awaited_results.push_back(edit_line(word_on_bus));
				words_sent++;
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (key_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					word_on_bus = key_words.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= {word_on_bus.idx, word_on_bus.key};
					s_axis_tuser <= word_on_bus.op;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// monitor and receiver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				words_checked++;
				if (m_axis_tuser <= 3'd5)
					events_seen[m_axis_tuser]++;
				if (awaited_results.size() == 0) begin
					$error("result word with nothing expected, event_res %0d", m_axis_tuser);
					fails++;
				end else begin
					line_result_t want;
					want = awaited_results.pop_front();
					check_field("event_res", 8'(want.ev), 8'(m_axis_tuser));
					check_field("length_now", want.len, m_axis_tdata[7:0]);
					check_field("cursor_now", want.cur, m_axis_tdata[15:8]);
					check_field("char_read", want.ch, m_axis_tdata[23:16]);
				end
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else if (hold_req != hold_ack) begin
				hold_ack = hold_req;
				hold_left = HOLD_CYCLES;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no word moved for %0d cycles", idle_cycles);
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	initial begin
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: dead keys, printable extremes, escape editing, reads, done and clear
		queue_key(KEY_BS);
		queue_key(KEY_CR);
		queue_key(8'd0);
		queue_key(8'd255);
		queue_key(KEY_SPACE);
		queue_key(KEY_TILDE);
		queue_key("q");
		queue_key(KEY_ESC);
		queue_key(KEY_BRACKET);
		queue_key(KEY_LEFT);
		queue_key(KEY_ESC);
		queue_key(KEY_BRACKET);
		queue_key(KEY_THREE);
		queue_key(KEY_TILDE);
		queue_key(KEY_ESC);
		queue_key(KEY_BRACKET);
		queue_key(KEY_RIGHT);
		queue_key(KEY_DEL);
		queue_read(8'd0);
		queue_read(8'd255);
		queue_key(KEY_ESC);
		queue_key(KEY_NL);
		queue_key(KEY_CR);
		queue_key(KEY_NL);
		queue_key("z");
		wait_drained();

		// long receiver hold while the sender keeps offering
		@(negedge clk);
		hold_req++;
		run_random_phase(0, 0, 380);
		run_random_phase(57, 0, 380);
		run_random_phase(0, 57, 380);
		run_random_phase(8, 8, 380);

		// full line: saturate, then edit at the head of a full line
		queue_key(KEY_NL);
		for (int i = 0; i < LINE_CAPACITY + 2; i++)
			queue_key(8'($urandom_range(126, 32)));
		queue_read(8'd254);
		queue_read(8'd255);
		queue_key(KEY_ESC);
		queue_key(KEY_BRACKET);
		queue_key(KEY_HOME);
		queue_key("x");
		queue_key(KEY_ESC);
		queue_key(KEY_BRACKET);
		queue_key(KEY_THREE);
		queue_key(KEY_TILDE);
		queue_key(KEY_ESC);
		queue_key(KEY_BRACKET);
		queue_key(KEY_END);
		queue_key(KEY_BS);
		run_random_phase(0, 0, 100);

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (awaited_results.size() != 0) begin
			$error("%0d expected results never arrived", awaited_results.size());
			fails++;
		end
		$display("sent %0d words, checked %0d results under four idle patterns and a full line",
			words_sent, words_checked);
		$display("events: none %0d redraw %0d done %0d up %0d down %0d read %0d",
			events_seen[0], events_seen[1], events_seen[2], events_seen[3],
			events_seen[4], events_seen[5]);
		if (fails == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

>>> files.f
design/tle_pkg.sv
design/tle_ram.sv
design/terminal_line_editor_top.sv
sim/tb_top.sv
